// ----- rtl/hpid_pkg.sv -----
package hpid_pkg;

    // field widths
    localparam int HEADING_W = 17;
    localparam int ERR_W     = 16;
    localparam int INTEG_W   = 24;
    localparam int DERIV_W   = 17;
    localparam int GAIN_W    = 24;
    localparam int ILIM_W    = 23;
    localparam int CLIM_W    = 12;
    localparam int DB_W      = 15;
    localparam int BASE_W    = 11;
    localparam int SPEED_W   = 12;
    localparam int CORR_W    = 12;

    // wrap arithmetic on the raw heading difference
    localparam int WRAP_W     = HEADING_W + 2;
    localparam int WRAP_STEPS = 3;
    localparam logic signed [WRAP_W-1:0] HALF_TURN   = 19'sd18000;
    localparam logic signed [WRAP_W-1:0] FULL_TURN   = 19'sd36000;
    localparam logic signed [WRAP_W-1:0] COARSE_LIM  = 19'sd126000;
    localparam logic signed [WRAP_W-1:0] COARSE_TURN = 19'sd144000;

    // gain products are Q16
    localparam int Q16_SHIFT = 16;
    localparam int PROD_P_W  = GAIN_W + 1 + ERR_W;
    localparam int PROD_I_W  = GAIN_W + 1 + INTEG_W;
    localparam int PROD_D_W  = GAIN_W + 1 + DERIV_W;
    localparam int SUM_W     = PROD_I_W + 1;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    typedef enum logic [2:0] {
        REG_GAIN_P           = 3'd0,
        REG_GAIN_I           = 3'd1,
        REG_GAIN_D           = 3'd2,
        REG_INTEGRAL_LIMIT   = 3'd3,
        REG_CORRECTION_LIMIT = 3'd4,
        REG_DEADBAND         = 3'd5,
        REG_BASE_SPEED       = 3'd6
    } reg_index_t;

    typedef struct packed {
        logic [DB_W-1:0]   deadband;
        logic [ILIM_W-1:0] integral_limit;
    } err_cfg_t;

    typedef struct packed {
        logic                      valid;
        logic signed [ERR_W-1:0]   err;
        logic signed [INTEG_W-1:0] integ;
        logic signed [DERIV_W-1:0] deriv;
    } err_stage_t;

endpackage

// ----- rtl/hpid_error_unit.sv -----
module hpid_error_unit (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   load,
    input  logic                                   in_valid,
    input  logic signed [hpid_pkg::HEADING_W-1:0]  desired_hdg,
    input  logic signed [hpid_pkg::HEADING_W-1:0]  gyro_hdg,
    input  logic                                   restart,
    input  hpid_pkg::err_cfg_t                     cfg,
    output hpid_pkg::err_stage_t                   stage_out
);

    logic signed [hpid_pkg::WRAP_W-1:0]  wrapped;
    logic        [hpid_pkg::WRAP_W-1:0]  magnitude;
    logic signed [hpid_pkg::ERR_W-1:0]   err_next;
    logic signed [hpid_pkg::INTEG_W-1:0] integ_base;
    logic signed [hpid_pkg::ERR_W-1:0]   prev_base;
    logic                                has_base;
    logic signed [hpid_pkg::INTEG_W:0]   integ_sum;
    logic signed [hpid_pkg::INTEG_W:0]   integ_lim;
    logic signed [hpid_pkg::INTEG_W-1:0] integ_next;
    logic signed [hpid_pkg::DERIV_W-1:0] deriv_next;

    logic signed [hpid_pkg::INTEG_W-1:0] integ_state_reg;
    logic signed [hpid_pkg::ERR_W-1:0]   prev_err_reg;
    logic                                has_prev_reg;
    logic                                valid_reg;
    logic signed [hpid_pkg::ERR_W-1:0]   err_reg;
    logic signed [hpid_pkg::INTEG_W-1:0] integ_reg;
    logic signed [hpid_pkg::DERIV_W-1:0] deriv_reg;

    always_comb begin
        wrapped = hpid_pkg::WRAP_W'(desired_hdg) - hpid_pkg::WRAP_W'(gyro_hdg);
        // far-out differences come in by four turns first; three single turns then suffice
        if (wrapped > hpid_pkg::COARSE_LIM) begin
            wrapped = wrapped - hpid_pkg::COARSE_TURN;
        end else if (wrapped < -hpid_pkg::COARSE_LIM) begin
            wrapped = wrapped + hpid_pkg::COARSE_TURN;
        end
        for (int i = 0; i < hpid_pkg::WRAP_STEPS; i++) begin
            if (wrapped > hpid_pkg::HALF_TURN) begin
                wrapped = wrapped - hpid_pkg::FULL_TURN;
            end else if (wrapped < -hpid_pkg::HALF_TURN) begin
                wrapped = wrapped + hpid_pkg::FULL_TURN;
            end
        end
        magnitude = (wrapped < 0) ? hpid_pkg::WRAP_W'(-wrapped)
                                  : hpid_pkg::WRAP_W'(wrapped);
        if (magnitude <= hpid_pkg::WRAP_W'(cfg.deadband)) begin
            err_next = '0;
        end else begin
            err_next = hpid_pkg::ERR_W'(wrapped);
        end

        integ_base = restart ? '0 : integ_state_reg;
        prev_base  = restart ? '0 : prev_err_reg;
        has_base   = restart ? 1'b0 : has_prev_reg;

        integ_sum = (hpid_pkg::INTEG_W+1)'(integ_base) + (hpid_pkg::INTEG_W+1)'(err_next);
        integ_lim = $signed({2'b00, cfg.integral_limit});
        if (integ_sum > integ_lim) begin
            integ_next = hpid_pkg::INTEG_W'(integ_lim);
        end else if (integ_sum < -integ_lim) begin
            integ_next = hpid_pkg::INTEG_W'(-integ_lim);
        end else begin
            integ_next = hpid_pkg::INTEG_W'(integ_sum);
        end

        if (has_base) begin
            deriv_next = hpid_pkg::DERIV_W'(err_next) - hpid_pkg::DERIV_W'(prev_base);
        end else begin
            deriv_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integ_state_reg <= '0;
            prev_err_reg    <= '0;
            has_prev_reg    <= 1'b0;
            valid_reg       <= 1'b0;
        end else if (load) begin
            valid_reg <= in_valid;
            if (in_valid) begin
                integ_state_reg <= integ_next;
                prev_err_reg    <= err_next;
                has_prev_reg    <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load && in_valid) begin
            err_reg   <= err_next;
            integ_reg <= integ_next;
            deriv_reg <= deriv_next;
        end
    end

    assign stage_out.valid = valid_reg;
    assign stage_out.err   = err_reg;
    assign stage_out.integ = integ_reg;
    assign stage_out.deriv = deriv_reg;

endmodule

// ----- rtl/heading_pid_differential_drive_unit.sv -----
// Heading PID controller for a differential-drive base.
// Input stream (s_): one control tick per transfer, target and measured heading in
// centidegrees, restart flag on s_tuser. Result stream (m_): left and right wheel
// speeds, the clamped correction and the wrapped, deadbanded heading error.
// Gains and limits are written over the APB port; the user must write them only while
// the stream is idle, as the block itself does not enforce it. From an input transfer
// to m_tvalid a tick passes the input register, the error and integral stage, the gain
// multiplies and the sum/clamp into the output register.
// Throughput: one tick per cycle while m_tready holds; the integral and previous error
// are updated in the error stage as each tick loads, which is what sets the rate.
// Each stage only holds while the stage after it is full and stalled, so a stalled
// receiver fills the pipeline and then drops s_tready; bubbles are squeezed out.
// Reset (aresetn low, synchronous) clears the configuration registers, the integral
// sum, the previous error and the pipeline valids.
module heading_pid_differential_drive_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    // APB configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [hpid_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [hpid_pkg::APB_DATA_W-1:0] pwdata,
    output logic [hpid_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [39:0]                     s_tdata,  // target[16:0], measured[33:17], pad
    input  logic                            s_tuser,  // restart
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // left[11:0], right[23:12], correction[35:24], heading error[51:36], pad
    output logic [55:0]                     m_tdata
);

    logic [hpid_pkg::GAIN_W-1:0] gain_p_reg;
    logic [hpid_pkg::GAIN_W-1:0] gain_i_reg;
    logic [hpid_pkg::GAIN_W-1:0] gain_d_reg;
    logic [hpid_pkg::ILIM_W-1:0] integral_limit_reg;
    logic [hpid_pkg::CLIM_W-1:0] correction_limit_reg;
    logic [hpid_pkg::DB_W-1:0]   deadband_reg;
    logic [hpid_pkg::BASE_W-1:0] base_speed_reg;

    hpid_pkg::reg_index_t reg_index;
    logic                 cfg_write;

    assign pready    = 1'b1;
    assign reg_index = hpid_pkg::reg_index_t'(paddr[hpid_pkg::APB_ADDR_W-1:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_p_reg           <= '0;
            gain_i_reg           <= '0;
            gain_d_reg           <= '0;
            integral_limit_reg   <= '0;
            correction_limit_reg <= '0;
            deadband_reg         <= '0;
            base_speed_reg       <= '0;
        end else if (cfg_write) begin
            unique case (reg_index)
                hpid_pkg::REG_GAIN_P:           gain_p_reg <= pwdata[hpid_pkg::GAIN_W-1:0];
                hpid_pkg::REG_GAIN_I:           gain_i_reg <= pwdata[hpid_pkg::GAIN_W-1:0];
                hpid_pkg::REG_GAIN_D:           gain_d_reg <= pwdata[hpid_pkg::GAIN_W-1:0];
                hpid_pkg::REG_INTEGRAL_LIMIT:   integral_limit_reg <= pwdata[hpid_pkg::ILIM_W-1:0];
                hpid_pkg::REG_CORRECTION_LIMIT: correction_limit_reg <= pwdata[hpid_pkg::CLIM_W-1:0];
                hpid_pkg::REG_DEADBAND:         deadband_reg <= pwdata[hpid_pkg::DB_W-1:0];
                hpid_pkg::REG_BASE_SPEED:       base_speed_reg <= pwdata[hpid_pkg::BASE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_index)
            hpid_pkg::REG_GAIN_P:           prdata = hpid_pkg::APB_DATA_W'(gain_p_reg);
            hpid_pkg::REG_GAIN_I:           prdata = hpid_pkg::APB_DATA_W'(gain_i_reg);
            hpid_pkg::REG_GAIN_D:           prdata = hpid_pkg::APB_DATA_W'(gain_d_reg);
            hpid_pkg::REG_INTEGRAL_LIMIT:   prdata = hpid_pkg::APB_DATA_W'(integral_limit_reg);
            hpid_pkg::REG_CORRECTION_LIMIT: prdata = hpid_pkg::APB_DATA_W'(correction_limit_reg);
            hpid_pkg::REG_DEADBAND:         prdata = hpid_pkg::APB_DATA_W'(deadband_reg);
            hpid_pkg::REG_BASE_SPEED:       prdata = hpid_pkg::APB_DATA_W'(base_speed_reg);
            default:                        prdata = '0;
        endcase
    end

    // pipeline flow control
    logic in_valid_reg;
    logic mul_valid_reg;
    logic out_valid_reg;
    logic ready_out;
    logic ready_mul;
    logic ready_err;
    logic ready_in;
    hpid_pkg::err_stage_t err_stage;

    assign ready_out = !out_valid_reg || m_tready;
    assign ready_mul = !mul_valid_reg || ready_out;
    assign ready_err = !err_stage.valid || ready_mul;
    assign ready_in  = !in_valid_reg || ready_err;
    assign s_tready  = ready_in;

    // input register
    logic signed [hpid_pkg::HEADING_W-1:0] target_reg;
    logic signed [hpid_pkg::HEADING_W-1:0] measured_reg;
    logic                                  restart_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (ready_in) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready_in && s_tvalid) begin
            target_reg   <= $signed(s_tdata[16:0]);
            measured_reg <= $signed(s_tdata[33:17]);
            restart_reg  <= s_tuser;
        end
    end

    hpid_pkg::err_cfg_t err_cfg;
    assign err_cfg.deadband       = deadband_reg;
    assign err_cfg.integral_limit = integral_limit_reg;

    hpid_error_unit u_error (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (ready_err),
        .in_valid    (in_valid_reg),
        .desired_hdg (target_reg),
        .gyro_hdg    (measured_reg),
        .restart     (restart_reg),
        .cfg         (err_cfg),
        .stage_out   (err_stage)
    );

    // gain multiplies
    logic signed [hpid_pkg::GAIN_W:0]     gain_p_s;
    logic signed [hpid_pkg::GAIN_W:0]     gain_i_s;
    logic signed [hpid_pkg::GAIN_W:0]     gain_d_s;
    logic signed [hpid_pkg::PROD_P_W-1:0] prod_p_next;
    logic signed [hpid_pkg::PROD_I_W-1:0] prod_i_next;
    logic signed [hpid_pkg::PROD_D_W-1:0] prod_d_next;
    logic signed [hpid_pkg::PROD_P_W-1:0] prod_p_reg;
    logic signed [hpid_pkg::PROD_I_W-1:0] prod_i_reg;
    logic signed [hpid_pkg::PROD_D_W-1:0] prod_d_reg;
    logic signed [hpid_pkg::ERR_W-1:0]    mul_err_reg;

    assign gain_p_s    = $signed({1'b0, gain_p_reg});
    assign gain_i_s    = $signed({1'b0, gain_i_reg});
    assign gain_d_s    = $signed({1'b0, gain_d_reg});
    assign prod_p_next = hpid_pkg::PROD_P_W'(gain_p_s) * hpid_pkg::PROD_P_W'(err_stage.err);
    assign prod_i_next = hpid_pkg::PROD_I_W'(gain_i_s) * hpid_pkg::PROD_I_W'(err_stage.integ);
    assign prod_d_next = hpid_pkg::PROD_D_W'(gain_d_s) * hpid_pkg::PROD_D_W'(err_stage.deriv);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_valid_reg <= 1'b0;
        end else if (ready_mul) begin
            mul_valid_reg <= err_stage.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready_mul && err_stage.valid) begin
            prod_p_reg  <= prod_p_next;
            prod_i_reg  <= prod_i_next;
            prod_d_reg  <= prod_d_next;
            mul_err_reg <= err_stage.err;
        end
    end

    // sum, floor, clamp and wheel speeds
    logic signed [hpid_pkg::SUM_W-1:0]   pid_sum;
    logic signed [hpid_pkg::SUM_W-1:0]   corr_raw;
    logic        [hpid_pkg::CLIM_W-1:0]  corr_lim;
    logic signed [hpid_pkg::SUM_W-1:0]   corr_lim_s;
    logic signed [hpid_pkg::CORR_W-1:0]  corr_next;
    logic        [hpid_pkg::SPEED_W-1:0] left_next;
    logic        [hpid_pkg::SPEED_W-1:0] right_next;

    always_comb begin
        pid_sum = hpid_pkg::SUM_W'(prod_p_reg) + hpid_pkg::SUM_W'(prod_i_reg)
                + hpid_pkg::SUM_W'(prod_d_reg);
        // arithmetic shift floors toward minus infinity
        corr_raw = pid_sum >>> hpid_pkg::Q16_SHIFT;
        if (hpid_pkg::CLIM_W'(base_speed_reg) < correction_limit_reg) begin
            corr_lim = hpid_pkg::CLIM_W'(base_speed_reg);
        end else begin
            corr_lim = correction_limit_reg;
        end
        corr_lim_s = $signed(hpid_pkg::SUM_W'(corr_lim));
        if (corr_raw > corr_lim_s) begin
            corr_next = hpid_pkg::CORR_W'(corr_lim_s);
        end else if (corr_raw < -corr_lim_s) begin
            corr_next = hpid_pkg::CORR_W'(-corr_lim_s);
        end else begin
            corr_next = hpid_pkg::CORR_W'(corr_raw);
        end
        left_next  = hpid_pkg::SPEED_W'(base_speed_reg) + hpid_pkg::SPEED_W'(corr_next);
        right_next = hpid_pkg::SPEED_W'(base_speed_reg) - hpid_pkg::SPEED_W'(corr_next);
    end

    logic [hpid_pkg::SPEED_W-1:0] left_reg;
    logic [hpid_pkg::SPEED_W-1:0] right_reg;
    logic [hpid_pkg::CORR_W-1:0]  corr_reg;
    logic [hpid_pkg::ERR_W-1:0]   out_err_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (ready_out) begin
            out_valid_reg <= mul_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready_out && mul_valid_reg) begin
            left_reg    <= left_next;
            right_reg   <= right_next;
            corr_reg    <= corr_next;
            out_err_reg <= mul_err_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_err_reg, corr_reg, right_reg, left_reg};

endmodule
